// ===== src/hslb_pkg.sv =====
package hslb_pkg;

    // pipelined divider: quotient width, register stages, bits per stage
    localparam int DIV_QW     = 26;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BPS    = (DIV_QW + DIV_STAGES - 1) / DIV_STAGES;

    // ceil(2^31 / 255); floor(a * LIN_RECIP >> 31) == floor(a / 255) for a < 2^24
    localparam logic [23:0] LIN_RECIP = 24'd8421505;

    // partial remainder and quotient carried between divider stages
    typedef struct packed {
        logic [9:0]  rem;
        logic [25:0] quo;
    } t_div_acc;

    // channel output: ceil(v2*255/131072), saturated, v2 signed
    function automatic logic [7:0] chan_out(input logic signed [19:0] v2);
        logic [27:0] t;
        begin
            if (v2 <= 0) begin
                chan_out = 8'd0;
            end else begin
                t = ({8'd0, v2} * 28'd255 + 28'd131071) >> 17;
                chan_out = (t > 28'd255) ? 8'd255 : t[7:0];
            end
        end
    endfunction

endpackage

// ===== src/hslb_div.sv =====
// Pipelined restoring divider: quotient of i_num/i_den, i_den<=510.
// DIV_BPS quotient bits per stage, DIV_QW bits over DIV_STAGES stages.
module hslb_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [25:0] i_num,
    input  logic [8:0]  i_den,
    output logic [25:0] o_quo
);
    import hslb_pkg::*;

    logic [25:0] r_n   [DIV_STAGES];
    logic [8:0]  r_d   [DIV_STAGES];
    t_div_acc    r_acc [DIV_STAGES];

    // one group of compare-and-subtract steps, starting at quotient bit base
    function automatic t_div_acc div_group(input t_div_acc acc, input logic [25:0] n,
                                           input logic [8:0] d, input int base);
        t_div_acc    a;
        logic [10:0] tr;
        a = acc;
        for (int k = 0; k < DIV_BPS; k++) begin
            if (base + k < DIV_QW) begin
                tr = {a.rem, n[DIV_QW-1-(base+k)]};
                if (tr >= {2'd0, d} && d != 9'd0) begin
                    tr    = tr - {2'd0, d};
                    a.quo = {a.quo[24:0], 1'b1};
                end else begin
                    a.quo = {a.quo[24:0], 1'b0};
                end
                a.rem = tr[9:0];
            end
        end
        return a;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= i_num;
            r_d[0]   <= i_den;
            r_acc[0] <= div_group('0, i_num, i_den, 0);
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_n[s]   <= r_n[s-1];
                r_d[s]   <= r_d[s-1];
                r_acc[s] <= div_group(r_acc[s-1], r_n[s-1], r_d[s-1], s * DIV_BPS);
            end
        end
    end

    assign o_quo = r_acc[DIV_STAGES-1].quo;

endmodule

// ===== src/hsl_luminance_blend_pixel_top.sv =====
// Pipeline: 8 register stages from the input transfer to the output register.
// Throughput: one pixel per clock; a stall freezes the whole pipeline.
// The four divider stages (hue and saturation) set the depth.
// Reset: synchronous, active low; clears the pipeline valid bits only.
// Output register always drains independently of new input.
module hsl_luminance_blend_pixel_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // red_in, green_in, blue_in, target_bit, blend_weight, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // red_out, green_out, blue_out, lightness_error, pad
);
    import hslb_pkg::*;

    // whole pipe advances when output slot is free or empty
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---- stage 1: min/max, sector, numerators
    logic [7:0] r, g, b;
    logic       q;
    logic [8:0] w;
    assign r = s_axis_tdata[7:0];
    assign g = s_axis_tdata[15:8];
    assign b = s_axis_tdata[23:16];
    assign q = s_axis_tdata[24];
    assign w = (s_axis_tdata[33:25] > 9'd256) ? 9'd256 : s_axis_tdata[33:25];

    logic       r_s1_v, r_s1_q, r_s1_neg;
    logic [8:0] r_s1_w, r_s1_sum, r_s1_den;
    logic [7:0] r_s1_d, r_s1_num;
    logic [2:0] r_s1_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [7:0] mx, mn;
            logic [8:0] sm;
            mx = (r > g) ? r : g;  mx = (mx > b) ? mx : b;
            mn = (r < g) ? r : g;  mn = (mn < b) ? mn : b;
            sm = {1'b0, mx} + {1'b0, mn};
            r_s1_q   <= q;
            r_s1_w   <= w;
            r_s1_sum <= sm;
            r_s1_d   <= mx - mn;
            r_s1_den <= (sm < 9'd510 - sm) ? sm : 9'd510 - sm;
            priority if (mx == r && g >= b) begin
                r_s1_sec <= 3'd0; r_s1_neg <= 1'b0; r_s1_num <= g - b;
            end else if (mx == r) begin
                r_s1_sec <= 3'd6; r_s1_neg <= 1'b1; r_s1_num <= b - g;
            end else if (mx == g) begin
                r_s1_sec <= 3'd2; r_s1_neg <= (b < r);
                r_s1_num <= (b >= r) ? b - r : r - b;
            end else begin
                r_s1_sec <= 3'd4; r_s1_neg <= (r < g);
                r_s1_num <= (r >= g) ? r - g : g - r;
            end
        end
    end

    // ---- dividers (stages 2..5): S, hue fraction
    logic [25:0] q_s, q_h;
    hslb_div u_div_s (.i_clk(i_clk), .i_en(en),
        .i_num(26'({r_s1_d, 16'd0}) + 26'(r_s1_den >> 1)),
        .i_den(r_s1_den), .o_quo(q_s));
    hslb_div u_div_h (.i_clk(i_clk), .i_en(en),
        .i_num(26'({r_s1_num, 16'd0}) + 26'(r_s1_d >> 1)),
        .i_den({1'b0, r_s1_d}), .o_quo(q_h));

    // side-band delay matching the dividers; L = round(sum*65536/510) by
    // reciprocal multiply in the first slot
    logic        r_dv  [DIV_STAGES];
    logic        r_dq  [DIV_STAGES];
    logic        r_dn  [DIV_STAGES];
    logic        r_dz  [DIV_STAGES];
    logic [8:0]  r_dw  [DIV_STAGES];
    logic [2:0]  r_dsc [DIV_STAGES];
    logic [16:0] r_dl  [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_STAGES; i++) r_dv[i] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_s1_v;
            for (int i = 1; i < DIV_STAGES; i++) r_dv[i] <= r_dv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [23:0] la;
            logic [47:0] lp;
            // (sum*32768 + 127) / 255 equals the half-up rounded sum*65536/510
            la = {r_s1_sum, 15'd0} + 24'd127;
            lp = 48'(la) * 48'(LIN_RECIP);
            r_dl[0]  <= 17'(lp >> 31);
            r_dq[0]  <= r_s1_q;
            r_dn[0]  <= r_s1_neg;
            r_dz[0]  <= (r_s1_d == 8'd0);
            r_dw[0]  <= r_s1_w;
            r_dsc[0] <= r_s1_sec;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_dl[i]  <= r_dl[i-1];
                r_dq[i]  <= r_dq[i-1];
                r_dn[i]  <= r_dn[i-1];
                r_dz[i]  <= r_dz[i-1];
                r_dw[i]  <= r_dw[i-1];
                r_dsc[i] <= r_dsc[i-1];
            end
        end
    end

    // ---- stage 6: hue, Lout (one multiply)
    logic        r_s6_v;
    logic [16:0] r_s6_lin, r_s6_lout, r_s6_sat;
    logic [18:0] r_s6_hue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s6_v <= 1'b0;
        else if (en)  r_s6_v <= r_dv[DIV_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [16:0] lin;
            logic [26:0] pr;
            logic [18:0] hb;
            lin = r_dl[DIV_STAGES-1];
            pr  = 27'(lin) * 27'(r_dw[DIV_STAGES-1]) + 27'd128;
            hb  = 19'(r_dsc[DIV_STAGES-1]) << 16;
            r_s6_lin  <= lin;
            r_s6_lout <= 17'((r_dq[DIV_STAGES-1] ?
                              27'(17'd256 * 17'(9'd256 - r_dw[DIV_STAGES-1])) : 27'd0)
                             + (pr >> 8));
            r_s6_sat  <= r_dz[DIV_STAGES-1] ? 17'd0 : q_s[16:0];
            r_s6_hue  <= r_dz[DIV_STAGES-1] ? 19'd0 :
                         (r_dn[DIV_STAGES-1] ? hb - 19'(q_h[16:0]) : hb + 19'(q_h[16:0]));
        end
    end

    // ---- stage 7: chroma
    logic        r_s7_v;
    logic [16:0] r_s7_c, r_s7_lin, r_s7_lout, r_s7_f;
    logic [2:0]  r_s7_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s7_v <= 1'b0;
        else if (en)  r_s7_v <= r_s6_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [17:0] tl, om;
            logic [34:0] pc;
            logic [16:0] fr;
            logic [2:0]  sc;
            tl = {r_s6_lout, 1'b0} - 18'd65536;
            if (tl[17]) tl = -tl;
            om = 18'd65536 - tl;
            pc = 35'(om) * 35'(r_s6_sat) + 35'd32768;
            fr = r_s6_hue[16:0];
            sc = r_s6_hue[18:16];
            r_s7_c    <= 17'(pc >> 16);
            r_s7_f    <= (fr >= 17'd65536) ? fr - 17'd65536 : 17'd65536 - fr;
            r_s7_sec  <= (sc > 3'd5) ? 3'd5 : sc;
            r_s7_lin  <= r_s6_lin;
            r_s7_lout <= r_s6_lout;
        end
    end

    // ---- stage 8: X and output channels
    logic        r_s8_v;
    logic [47:0] r_s8_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s8_v <= 1'b0;
        else if (en)  r_s8_v <= r_s7_v;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            logic [34:0] px;
            logic [16:0] x, cr, cg, cb;
            logic signed [19:0] tl2;
            logic [16:0] er;
            px = 35'(r_s7_c) * 35'(17'd65536 - r_s7_f) + 35'd32768;
            x  = 17'(px >> 16);
            unique case (r_s7_sec)
                3'd0:    begin cr = r_s7_c; cg = x;      cb = '0;     end
                3'd1:    begin cr = x;      cg = r_s7_c; cb = '0;     end
                3'd2:    begin cr = '0;     cg = r_s7_c; cb = x;      end
                3'd3:    begin cr = '0;     cg = x;      cb = r_s7_c; end
                3'd4:    begin cr = x;      cg = '0;     cb = r_s7_c; end
                default: begin cr = r_s7_c; cg = '0;     cb = x;      end
            endcase
            tl2 = 20'sd2 * $signed({3'd0, r_s7_lout}) - $signed({3'd0, r_s7_c});
            er  = (r_s7_lout >= r_s7_lin) ? r_s7_lout - r_s7_lin : r_s7_lin - r_s7_lout;
            r_s8_d <= {7'd0, er,
                       chan_out(20'sd2 * $signed({3'd0, cb}) + tl2),
                       chan_out(20'sd2 * $signed({3'd0, cg}) + tl2),
                       chan_out(20'sd2 * $signed({3'd0, cr}) + tl2)};
        end
    end

    assign m_axis_tvalid = r_s8_v;
    assign m_axis_tdata  = r_s8_d;

    // result must hold while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:41] == 7'd0)
        else $error("padding not zero");

endmodule

// ===== bench/hsl_luminance_blend_pixel_top_test.sv =====
`timescale 1ns / 1ps

module hsl_luminance_blend_pixel_top_test;

    // Expected pixel after the lightness blend
    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [16:0] l_err;
    } t_blend_px;

    localparam int unsigned Q16       = 65536;
    localparam int unsigned WD_LIMIT  = 20000;
    localparam int unsigned DRAIN_CYC = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // red, green, blue, target bit, weight, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // red, green, blue, lightness error, zero pad

    t_blend_px   pending_px[$];
    int unsigned mismatch_cnt;
    int unsigned idle_cycles;
    bit          sink_hold;      // forces a long hold-off on the result side
    bit          sink_quiet;     // no random stalls on the result side

    hsl_luminance_blend_pixel_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Round-half-up quotient; zero divisor gives zero
    function automatic longint unsigned rdiv(input longint unsigned n,
                                             input longint unsigned dv);
        if (dv == 0) return 0;
        return (n + dv / 2) / dv;
    endfunction

    function automatic logic [7:0] to_chan(input longint v2);
        longint unsigned t;
        if (v2 <= 0) return 8'd0;
        t = (longint'(v2) * 255 + 131071) >> 17;
        return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    function automatic t_blend_px blend_pixel(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic tgt,
                                              input logic [8:0] wt);
        t_blend_px       px;
        longint          rr, gg, bb, mx, mn, dd, sm, den, tl, cr, cg, cb;
        longint unsigned w, lin, sat, hue, lout, c, x, fr, f;
        int unsigned     sector;
        rr = r; gg = g; bb = b;
        w   = (wt > 256) ? 256 : wt;
        sat = 0;
        hue = 0;
        mx = (rr > gg) ? rr : gg; mx = (mx > bb) ? mx : bb;
        mn = (rr < gg) ? rr : gg; mn = (mn < bb) ? mn : bb;
        dd = mx - mn;
        sm = mx + mn;
        lin = rdiv(sm * Q16, 510);
        if (dd != 0) begin
            den = (sm < 510 - sm) ? sm : 510 - sm;
            sat = rdiv(dd * Q16, den);
            if (mx == rr && gg >= bb)      hue = rdiv((gg - bb) * Q16, dd);
            else if (mx == rr)             hue = 6 * Q16 - rdiv((bb - gg) * Q16, dd);
            else if (mx == gg && bb >= rr) hue = 2 * Q16 + rdiv((bb - rr) * Q16, dd);
            else if (mx == gg)             hue = 2 * Q16 - rdiv((rr - bb) * Q16, dd);
            else if (rr >= gg)             hue = 4 * Q16 + rdiv((rr - gg) * Q16, dd);
            else                           hue = 4 * Q16 - rdiv((gg - rr) * Q16, dd);
        end
        lout = tgt * 256 * (256 - w) + ((lin * w + 128) >> 8);
        tl = 2 * longint'(lout) - Q16;
        if (tl < 0) tl = -tl;
        c  = (longint'(Q16 - tl) * sat + 32768) >> 16;
        fr = hue & 'h1FFFF;
        f  = (fr >= Q16) ? fr - Q16 : Q16 - fr;
        x  = (c * (Q16 - f) + 32768) >> 16;
        sector = 32'(hue >> 16);
        if (sector > 5) sector = 5;
        case (sector)
            0: begin cr = c; cg = x; cb = 0; end
            1: begin cr = x; cg = c; cb = 0; end
            2: begin cr = 0; cg = c; cb = x; end
            3: begin cr = 0; cg = x; cb = c; end
            4: begin cr = x; cg = 0; cb = c; end
            default: begin cr = c; cg = 0; cb = x; end
        endcase
        tl = 2 * longint'(lout) - longint'(c);
        px.red   = to_chan(2 * cr + tl);
        px.green = to_chan(2 * cg + tl);
        px.blue  = to_chan(2 * cb + tl);
        px.l_err = 17'((lout >= lin) ? lout - lin : lin - lout);
        return px;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatch_cnt++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one pixel and wait for its transfer
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic tgt, input logic [8:0] wt, input bit gaps);
        int unsigned n;
        n = gaps ? gap_len() : 0;
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, wt, tgt, b, g, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_px = {pending_px, blend_pixel(r, g, b, tgt, wt)};
        @(negedge i_clk);
    endtask

    task automatic send_random(input int unsigned cnt, input bit gaps);
        repeat (cnt) begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                       9'($urandom_range(0, 511)), gaps);
        end
    endtask

    // Corners of the fields, grays, each hue sector and weights above one
    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 9'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 9'd511, 1'b0);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b1, 9'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 9'd0,   1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1, 9'd256, 1'b0);
        send_pixel(8'd77,  8'd77,  8'd77,  1'b0, 9'd257, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b1, 9'd128, 1'b0);
        send_pixel(8'd255, 8'd200, 8'd10,  1'b0, 9'd200, 1'b0);
        send_pixel(8'd100, 8'd255, 8'd0,   1'b1, 9'd64,  1'b0);
        send_pixel(8'd0,   8'd255, 8'd150, 1'b0, 9'd300, 1'b0);
        send_pixel(8'd0,   8'd90,  8'd255, 1'b1, 9'd255, 1'b0);
        send_pixel(8'd160, 8'd0,   8'd255, 1'b0, 9'd1,   1'b0);
        send_pixel(8'd255, 8'd0,   8'd40,  1'b1, 9'd450, 1'b0);
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0, 9'd256, 1'b0);
        send_pixel(8'd255, 8'd254, 8'd255, 1'b1, 9'd256, 1'b0);
        send_pixel(8'd170, 8'd85,  8'd85,  1'b1, 9'd170, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0, 9'd511, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b1, 9'd2,   1'b0);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_random_gaps();
        send_random(300, 1'b1);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Result side held off while pixels keep coming, so the input stalls
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            send_random(60, 1'b0);
        join
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Full rate on both sides, then random traffic to round off
    task automatic test_streaming();
        sink_quiet = 1'b1;
        send_random(150, 1'b0);
        sink_quiet = 1'b0;
        send_random(170, 1'b1);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Result side stalls, driven at the falling edge
    always @(negedge i_clk) begin
        if (sink_hold) begin
            m_axis_tready <= 1'b0;
        end else if (sink_quiet) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                             ($urandom_range(0, 99) < 50);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_blend_px want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_px.size() == 0) begin
                report_mismatch("result with no pixel outstanding",
                                longint'(m_axis_tdata), 64'sd0);
            end else begin
                want = pending_px.pop_front();
                if (m_axis_tdata[7:0] !== want.red)
                    report_mismatch("red", longint'(m_axis_tdata[7:0]), longint'(want.red));
                if (m_axis_tdata[15:8] !== want.green)
                    report_mismatch("green", longint'(m_axis_tdata[15:8]),
                                    longint'(want.green));
                if (m_axis_tdata[23:16] !== want.blue)
                    report_mismatch("blue", longint'(m_axis_tdata[23:16]),
                                    longint'(want.blue));
                if (m_axis_tdata[40:24] !== want.l_err)
                    report_mismatch("lightness error", longint'(m_axis_tdata[40:24]),
                                    longint'(want.l_err));
            end
        end
    end

    // Watchdog: cycles without any transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int unsigned wait_cyc;
        mismatch_cnt  = 0;
        idle_cycles   = 0;
        sink_hold     = 1'b0;
        sink_quiet    = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_gaps();
        test_backpressure();
        test_streaming();

        wait_cyc = 0;
        while (pending_px.size() != 0 && wait_cyc < 100000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_px.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/hslb_pkg.sv
src/hslb_div.sv
src/hsl_luminance_blend_pixel_top.sv
bench/hsl_luminance_blend_pixel_top_test.sv
